/* design/hkrt_pkg.sv */
`timescale 1ns / 1ps
package hkrt_pkg;

  localparam int CHANNELS    = 32;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_BITS = 12;
  localparam int LEVEL_W     = SAMPLE_BITS + 8;
  localparam int TRAVEL_W    = 10;
  localparam int THR_W       = 10;
  localparam int SCALE_W     = 17;
  localparam int WEIGHT_W    = 9;

  localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = TRAVEL_W'(1000);

  // serial multiplier operand widths
  localparam int MUL_A_W = LEVEL_W + 1;
  localparam int MUL_B_W = SCALE_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_C_W = $clog2(MUL_B_W);

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_SEED   = 1'b1;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_RAPID = 2'd1;
  localparam logic [1:0] MODE_CONT  = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [TRAVEL_W-1:0] peak;
    logic [TRAVEL_W-1:0] valley;
    logic                active;
  } chan_state_t;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

endpackage

/* design/hkrt_ser_mul.sv */
`timescale 1ns / 1ps
module hkrt_ser_mul
  import hkrt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  mul_req_t                  req,
  output logic                      done,
  output logic signed [MUL_P_W-1:0] p
);

  logic signed [MUL_P_W-1:0] a_sh;
  logic [MUL_B_W-1:0]        b_sh;
  logic [MUL_C_W-1:0]        cnt;
  logic                      run;
  logic signed [MUL_P_W-1:0] acc;
  logic signed [MUL_P_W-1:0] term;
  logic                      last;

  assign term = b_sh[0] ? a_sh : '0;
  assign last = (cnt == MUL_C_W'(MUL_B_W - 1));
  assign p    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per cycle; the sign bit of b carries negative weight
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_sh <= MUL_P_W'(req.a);
      b_sh <= req.b;
      acc  <= '0;
    end else if (run) begin
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
      acc  <= last ? (acc - term) : (acc + term);
    end
  end

endmodule

/* design/hall_key_rapid_trigger.sv */
`timescale 1ns / 1ps
// Hall-effect key processor with fixed, rapid and continuous rapid trigger.
// Input channel s_axis_*: one item per sensor sample with its calibration and
// thresholds; tuser carries the request kind (update or seed). Output channel
// m_axis_*: exactly one item per input item, in order: channel, travel, pressed.
// cfg_wr_en / cfg_wr_data write the EMA smoothing weight (Q8); write it only
// while the block is idle.
// Each item is worked on alone. An update with smoothing runs two bit-serial
// multiplies (EMA step, then counts-to-travel); an update without smoothing or
// a seed skips the first multiply; an out-of-range channel skips both. The
// next item is accepted the cycle after the result moves into the output
// register.
// Reset clears all channel state (average, peak, valley, pressed) and the
// weight, with no clearing pass. When the receiver stalls, the result waits in
// the output register; one further item is accepted and worked on, then the
// block holds until the output register frees up.
module hall_key_rapid_trigger
  import hkrt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [8:0]   cfg_wr_data,    // smoothing_weight
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // channel, raw_sample, rest_level, travel_scale, actuation_point,
  // release_point, press_delta, release_delta, release_floor, trigger_mode
  input  logic [103:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata    // channel_out, travel_out, pressed
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_EMA   = 6'b000100,
    S_START = 6'b001000,
    S_MAP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [WEIGHT_W-1:0] weight;

  // captured item
  logic                   req_q;
  logic [4:0]             ch_q;
  logic [SAMPLE_BITS-1:0] raw_q;
  logic [11:0]            rest_q;
  logic [SCALE_W-1:0]     scale_q;
  logic [THR_W-1:0]       act_pt_q, rel_pt_q, press_d_q, rel_d_q, floor_q;
  logic [1:0]             mode_q;

  chan_state_t mem [CHANNELS];
  chan_state_t rd;
  logic        rd_vld;
  logic [CHANNELS-1:0] valid;
  chan_state_t cur;

  logic [LEVEL_W-1:0]  lvl;
  logic [TRAVEL_W-1:0] travel_q;
  logic                pressed_q;

  mul_req_t                  mreq;
  logic                      mdone;
  logic signed [MUL_P_W-1:0] mp;

  logic in_acc, out_free, ch_bad, direct;
  logic [CH_W-1:0] idx_in, idx_q;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign idx_in = s_axis_tdata[CH_W-1:0];
  assign idx_q  = ch_q[CH_W-1:0];
  assign ch_bad = ({1'b0, ch_q} >= 6'(CHANNELS));
  assign direct = (req_q == REQ_SEED) || (weight == '0);
  assign cur    = rd_vld ? rd : '0;

  hkrt_ser_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .p    (mp)
  );

  // EMA step: (raw<<8 - level) * weight, then average-to-travel
  logic signed [SAMPLE_BITS:0] diff;
  always_comb begin
    diff = $signed({1'b0, lvl[LEVEL_W-1:8]}) - $signed({1'b0, rest_q});
    mreq.start = 1'b0;
    mreq.a     = $signed({1'b0, raw_q, 8'b0}) - $signed({1'b0, cur.level});
    mreq.b     = $signed({(MUL_B_W - WEIGHT_W)'(0), weight});
    if (state == S_LOAD) begin
      mreq.start = !ch_bad && !direct;
    end else if (state == S_START) begin
      mreq.start = 1'b1;
      mreq.a     = MUL_A_W'(diff);
      mreq.b     = $signed(scale_q);
    end
  end

  // saturate the new average
  logic signed [MUL_P_W-9:0] ema_sum;
  logic [LEVEL_W-1:0]        ema_lvl;
  always_comb begin
    ema_sum = $signed({(MUL_P_W - 8 - LEVEL_W)'(0), cur.level})
            + $signed(mp[MUL_P_W-1:8]);
    if (ema_sum[MUL_P_W-9])
      ema_lvl = '0;
    else if (ema_sum[MUL_P_W-9:LEVEL_W] != '0)
      ema_lvl = '1;
    else
      ema_lvl = ema_sum[LEVEL_W-1:0];
  end

  // floor divide by 1024 and clamp to travel range
  logic [TRAVEL_W-1:0] travel;
  always_comb begin
    if (mp[MUL_P_W-1])
      travel = '0;
    else if (mp[MUL_P_W-2:10] > (MUL_P_W - 11)'(TRAVEL_MAX))
      travel = TRAVEL_MAX;
    else
      travel = mp[TRAVEL_W+9:10];
  end

  // trigger decision
  chan_state_t nxt;
  logic [TRAVEL_W-1:0] pk2, vl2;
  logic armed;
  always_comb begin
    nxt       = cur;
    nxt.level = lvl;
    pk2   = (travel > cur.peak) ? travel : cur.peak;
    vl2   = (travel < cur.valley) ? travel : cur.valley;
    armed = (mode_q == MODE_CONT) || (travel >= act_pt_q);
    if (req_q == REQ_SEED) begin
      nxt.peak   = travel;
      nxt.valley = travel;
      nxt.active = 1'b0;
    end else if (mode_q == MODE_FIXED) begin
      nxt.active = cur.active ? (travel >= rel_pt_q) : (travel >= act_pt_q);
    end else if (cur.active) begin
      nxt.peak = pk2;
      if (({1'b0, travel} + {1'b0, rel_d_q} <= {1'b0, pk2}) || (travel < floor_q)) begin
        nxt.active = 1'b0;
        nxt.valley = travel;
      end
    end else begin
      nxt.valley = vl2;
      if (armed && ({1'b0, travel} >= {1'b0, vl2} + {1'b0, press_d_q})) begin
        nxt.active = 1'b1;
        nxt.peak   = travel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      weight        <= '0;
      valid         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en)
        weight <= cfg_wr_data;
      if ((state == S_DONE) && out_free)
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)
        m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc)
            state <= S_LOAD;
        end
        S_LOAD: begin
          if (ch_bad)
            state <= S_DONE;
          else if (direct)
            state <= S_START;
          else
            state <= S_EMA;
        end
        S_EMA: begin
          if (mdone)
            state <= S_START;
        end
        S_START: state <= S_MAP;
        S_MAP: begin
          if (mdone) begin
            valid[idx_q] <= 1'b1;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload and channel memory
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_q     <= s_axis_tuser[0];
      ch_q      <= s_axis_tdata[4:0];
      raw_q     <= s_axis_tdata[5 +: SAMPLE_BITS];
      rest_q    <= s_axis_tdata[28:17];
      scale_q   <= s_axis_tdata[45:29];
      act_pt_q  <= s_axis_tdata[55:46];
      rel_pt_q  <= s_axis_tdata[65:56];
      press_d_q <= s_axis_tdata[75:66];
      rel_d_q   <= s_axis_tdata[85:76];
      floor_q   <= s_axis_tdata[95:86];
      mode_q    <= s_axis_tdata[97:96];
      rd        <= mem[idx_in];
      rd_vld    <= valid[idx_in];
    end
    case (state)
      S_LOAD: begin
        lvl       <= {raw_q, 8'b0};
        travel_q  <= '0;
        pressed_q <= 1'b0;
      end
      S_EMA: begin
        if (mdone)
          lvl <= ema_lvl;
      end
      S_MAP: begin
        if (mdone) begin
          mem[idx_q] <= nxt;
          travel_q   <= travel;
          pressed_q  <= nxt.active;
        end
      end
      S_DONE: begin
        if (out_free)
          m_axis_tdata <= {pressed_q, travel_q, ch_q};
      end
      default: ;
    endcase
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import hkrt_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 183;
  localparam logic [1:0] MODE_ALIAS = 2'd3;  // undefined code, acts as rapid

  typedef struct {
    logic               req;
    logic [4:0]         ch;
    logic [11:0]        raw;
    logic [11:0]        rest;
    logic signed [16:0] scale;
    logic [9:0]         act;
    logic [9:0]         rel;
    logic [9:0]         pd;
    logic [9:0]         rd;
    logic [9:0]         flr;
    logic [1:0]         mode;
  } sample_t;

  typedef struct {
    logic [4:0] ch;
    logic [9:0] travel;
    logic       pressed;
  } key_result_t;

  class key_scoreboard;
    bit [LEVEL_W-1:0]  level [CHANNELS];
    bit [TRAVEL_W-1:0] peak [CHANNELS];
    bit [TRAVEL_W-1:0] valley [CHANNELS];
    bit                active [CHANNELS];
    bit [8:0]          weight;
    key_result_t       expected_keys[$];
    int unsigned mismatches, checked, seeds, updates, fixed_n, rapid_n, cont_n;
    int unsigned presses, releases, weight_writes;

    function void set_weight(logic [8:0] w);
      weight = w;
      weight_writes++;
    endfunction

    function int pending();
      return expected_keys.size();
    endfunction

    function logic [9:0] travel_of(bit [LEVEL_W-1:0] lvl, logic [11:0] rest,
                                   logic signed [16:0] scale);
      longint t;
      t = ((longint'(lvl[LEVEL_W-1:8]) - longint'(rest)) * longint'(scale)) >>> 10;
      if (t < 0) t = 0;
      if (t > longint'(TRAVEL_MAX)) t = longint'(TRAVEL_MAX);
      return t[9:0];
    endfunction

    function void note_sample(logic req, logic [103:0] d);
      logic [4:0] ch;
      logic [11:0] raw, rest;
      logic signed [16:0] scale;
      logic [9:0] act, rel, pd, rd, flr, trav;
      logic [1:0] mode;
      longint cur, nxt;
      bit was;
      key_result_t r;
      ch = d[4:0];
      raw = d[16:5];
      rest = d[28:17];
      scale = d[45:29];
      act = d[55:46];
      rel = d[65:56];
      pd = d[75:66];
      rd = d[85:76];
      flr = d[95:86];
      mode = d[97:96];
      if (req == REQ_SEED) begin
        level[ch] = {raw, 8'h00};
        trav = travel_of(level[ch], rest, scale);
        peak[ch] = trav;
        valley[ch] = trav;
        active[ch] = 1'b0;
        seeds++;
      end else begin
        if (weight != 0) begin
          cur = longint'(level[ch]);
          nxt = cur + (((longint'({raw, 8'h00}) - cur) * longint'(weight)) >>> 8);
          if (nxt < 0) nxt = 0;
          if (nxt > (longint'(1) << LEVEL_W) - 1) nxt = (longint'(1) << LEVEL_W) - 1;
          level[ch] = nxt[LEVEL_W-1:0];
        end else begin
          level[ch] = {raw, 8'h00};
        end
        trav = travel_of(level[ch], rest, scale);
        was = active[ch];
        updates++;
        if (mode == MODE_FIXED) begin
          fixed_n++;
          active[ch] = was ? (trav >= rel) : (trav >= act);
        end else begin
          if (mode == MODE_CONT) cont_n++;
          else rapid_n++;
          if (was) begin
            if (trav > peak[ch]) peak[ch] = trav;
            if (int'(trav) + int'(rd) <= int'(peak[ch]) || trav < flr) begin
              active[ch] = 1'b0;
              valley[ch] = trav;
            end
          end else begin
            if (trav < valley[ch]) valley[ch] = trav;
            // continuous mode is always armed
            if ((mode == MODE_CONT || trav >= act) &&
                int'(trav) >= int'(valley[ch]) + int'(pd)) begin
              active[ch] = 1'b1;
              peak[ch] = trav;
            end
          end
        end
        if (!was && active[ch]) presses++;
        if (was && !active[ch]) releases++;
      end
      r.ch = ch;
      r.travel = trav;
      r.pressed = (req == REQ_SEED) ? 1'b0 : active[ch];
      expected_keys.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [15:0] d);
      key_result_t e;
      if (expected_keys.size() == 0) begin
        report($sformatf("result %h with nothing expected", d));
        return;
      end
      e = expected_keys.pop_front();
      checked++;
      if (d[4:0] !== e.ch)
        report($sformatf("result %0d channel %0d, want %0d", checked, d[4:0], e.ch));
      if (d[14:5] !== e.travel)
        report($sformatf("result %0d ch %0d travel %0d, want %0d", checked, e.ch,
                         d[14:5], e.travel));
      if (d[15] !== e.pressed)
        report($sformatf("result %0d ch %0d pressed %b, want %b", checked, e.ch,
                         d[15], e.pressed));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [8:0]   cfg_wr_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;

  key_scoreboard sb = new();

  int unsigned burst_left, hold_reqs, quiet;
  bit          gaps_on;

  hall_key_rapid_trigger DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Receiver: random stall styles, plus long hold-offs on request.
  int unsigned ready_style, style_left, hold_left, holds_served, cycle_no;
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_reqs) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        ready_style <= $urandom_range(0, 3);
        style_left <= $urandom_range(40, 300);
      end else begin
        style_left <= style_left - 1;
      end
      case (ready_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready <= (cycle_no % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) sb.set_weight(cfg_wr_data);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tuser[0], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic sample_t mk(int req, int ch, int raw, int rest, int scale, int act,
                                 int rel, int pd, int rd, int flr, int mode);
    sample_t it;
    it.req = 1'(req);
    it.ch = 5'(ch);
    it.raw = 12'(raw);
    it.rest = 12'(rest);
    it.scale = 17'(scale);
    it.act = 10'(act);
    it.rel = 10'(rel);
    it.pd = 10'(pd);
    it.rd = 10'(rd);
    it.flr = 10'(flr);
    it.mode = 2'(mode);
    return it;
  endfunction

  task automatic offer(input sample_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 30) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.req;
    s_axis_tdata <= {6'b0, it.mode, it.flr, it.rd, it.pd, it.rel, it.act, it.scale,
                     it.rest, it.raw, it.ch};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every expected result is in.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_smoothing(input logic [8:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] w, input int count, input bit squeeze);
    sample_t it;
    int sent, n, pos, v, act;
    bit held, paused;
    drain();
    repeat (4) @(posedge clk);
    set_smoothing(w);
    sent = 0;
    held = 0;
    paused = 0;
    while (sent < count) begin
      if (squeeze && !held && sent > count / 3) begin
        hold_reqs++;
        held = 1;
      end
      if (squeeze && !paused && sent > (3 * count) / 4) begin
        drain();
        paused = 1;
      end
      if ($urandom_range(0, 99) < 80) begin
        // keystroke: fixed calibration, sample walks up and down
        it.ch = 5'($urandom_range(0, CHANNELS - 1));
        it.rest = 12'($urandom_range(200, 3800));
        if ($urandom_range(0, 9) == 0) it.scale = 17'(-int'($urandom_range(256, 4096)));
        else it.scale = 17'($urandom_range(256, 8192));
        act = $urandom_range(50, 800);
        it.act = 10'(act);
        it.rel = 10'($urandom_range(0, act));
        it.pd = 10'($urandom_range(0, 200));
        it.rd = 10'($urandom_range(0, 200));
        it.flr = 10'($urandom_range(0, 150));
        it.mode = 2'($urandom_range(0, 3));
        pos = int'($urandom_range(0, 60)) - 30;
        if ($urandom_range(0, 4) != 0) begin
          v = int'(it.rest) + pos;
          it.req = REQ_SEED;
          it.raw = 12'((v < 0) ? 0 : (v > 4095) ? 4095 : v);
          offer(it);
          sent++;
        end
        it.req = REQ_UPDATE;
        n = $urandom_range(4, 24);
        repeat (n) begin
          pos += int'($urandom_range(0, 240)) - 120;
          if ($urandom_range(0, 9) == 0) pos = int'($urandom_range(0, 1400)) - 100;
          if (pos < -150) pos = -150;
          if (pos > 1500) pos = 1500;
          v = int'(it.rest) + pos;
          it.raw = 12'((v < 0) ? 0 : (v > 4095) ? 4095 : v);
          offer(it);
          sent++;
        end
      end else begin
        it.req = 1'($urandom);
        it.ch = 5'($urandom);
        it.raw = 12'($urandom);
        it.rest = 12'($urandom);
        it.scale = 17'($urandom);
        it.act = 10'($urandom);
        it.rel = 10'($urandom);
        it.pd = 10'($urandom);
        it.rd = 10'($urandom);
        it.flr = 10'($urandom);
        it.mode = 2'($urandom);
        offer(it);
        sent++;
      end
    end
  endtask

  logic [8:0] weight_plan [10];

  initial begin
    weight_plan = '{9'd0, 9'd256, 9'd1, 9'd511, 9'd128, 9'd257, 9'd32, 9'd0, 9'd200, 9'd0};
    weight_plan[7] = 9'($urandom_range(0, 511));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    gaps_on = 1;

    // extremes of scale and sample, full-range clamps
    offer(mk(REQ_UPDATE, 0, 4095, 0, 65535, 500, 400, 0, 0, 0, MODE_FIXED));
    offer(mk(REQ_UPDATE, 0, 0, 4095, -65536, 500, 400, 0, 0, 0, MODE_FIXED));
    offer(mk(REQ_UPDATE, 0, 0, 4095, 65535, 500, 400, 0, 0, 0, MODE_FIXED));
    // small negative product rounds down, then clamps
    offer(mk(REQ_SEED, 1, 1001, 1000, -1, 0, 0, 0, 0, 0, MODE_FIXED));
    offer(mk(REQ_SEED, 31, 4095, 4095, 0, 1023, 1023, 1023, 1023, 1023, MODE_ALIAS));
    offer(mk(REQ_UPDATE, 31, 4095, 0, 65535, 1023, 1023, 1023, 1023, 1023, MODE_ALIAS));
    // rapid: press, follow peak, release on delta, press again, release below floor
    offer(mk(REQ_SEED, 2, 1000, 1000, 1024, 50, 0, 30, 30, 10, MODE_RAPID));
    offer(mk(REQ_UPDATE, 2, 1100, 1000, 1024, 50, 0, 30, 30, 10, MODE_RAPID));
    offer(mk(REQ_UPDATE, 2, 1150, 1000, 1024, 50, 0, 30, 30, 10, MODE_RAPID));
    offer(mk(REQ_UPDATE, 2, 1120, 1000, 1024, 50, 0, 30, 30, 10, MODE_RAPID));
    offer(mk(REQ_UPDATE, 2, 1110, 1000, 1024, 50, 0, 30, 30, 10, MODE_RAPID));
    offer(mk(REQ_UPDATE, 2, 1160, 1000, 1024, 50, 0, 30, 30, 10, MODE_RAPID));
    offer(mk(REQ_UPDATE, 2, 1005, 1000, 1024, 50, 0, 30, 30, 10, MODE_RAPID));
    // continuous: press far below the actuation point
    offer(mk(REQ_SEED, 3, 2000, 2000, 1024, 900, 0, 20, 30, 0, MODE_CONT));
    offer(mk(REQ_UPDATE, 3, 2040, 2000, 1024, 900, 0, 20, 30, 0, MODE_CONT));
    offer(mk(REQ_UPDATE, 3, 2010, 2000, 1024, 900, 0, 20, 30, 0, MODE_CONT));
    offer(mk(REQ_SEED, 4, 500, 500, 2048, 100, 0, 50, 50, 0, MODE_ALIAS));
    offer(mk(REQ_UPDATE, 4, 600, 500, 2048, 100, 0, 50, 50, 0, MODE_ALIAS));
    // fixed hysteresis, including press exactly at the actuation point
    offer(mk(REQ_UPDATE, 5, 1700, 1000, 1024, 600, 400, 0, 0, 0, MODE_FIXED));
    offer(mk(REQ_UPDATE, 5, 1500, 1000, 1024, 600, 400, 0, 0, 0, MODE_FIXED));
    offer(mk(REQ_UPDATE, 5, 1300, 1000, 1024, 600, 400, 0, 0, 0, MODE_FIXED));
    offer(mk(REQ_UPDATE, 5, 1600, 1000, 1024, 600, 400, 0, 0, 0, MODE_FIXED));
    // zero deltas: press and release without movement
    offer(mk(REQ_SEED, 6, 3000, 3000, 1024, 0, 0, 0, 0, 0, MODE_RAPID));
    offer(mk(REQ_UPDATE, 6, 3000, 3000, 1024, 0, 0, 0, 0, 0, MODE_RAPID));
    offer(mk(REQ_UPDATE, 6, 3000, 3000, 1024, 0, 0, 0, 0, 0, MODE_RAPID));

    for (int i = 0; i < 10; i++) begin
      gaps_on = (i % 3 != 2);
      run_phase(weight_plan[i], PHASE_ITEMS, (i == 3 || i == 7));
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("covered %0d seeds and %0d updates (fixed %0d, rapid %0d, continuous %0d)",
             sb.seeds, sb.updates, sb.fixed_n, sb.rapid_n, sb.cont_n);
    $display("%0d presses, %0d releases, %0d results checked, %0d smoothing settings",
             sb.presses, sb.releases, sb.checked, sb.weight_writes);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
